/* hdl/gsp_pkg.sv */
// ---------------------------------------------------------------------------
// gsp_pkg
// Shared types and constants of the grid span first-fit placer.
// ---------------------------------------------------------------------------
package gsp_pkg;

  localparam int DEF_MAX_COLS = 16;
  localparam int DEF_MAX_ROWS = 64;

  // item field widths
  localparam int CMD_W       = 1;
  localparam int COL_SPAN_W  = 5;
  localparam int ROW_SPAN_W  = 7;
  localparam int SLOT_COL_W  = 4;
  localparam int SLOT_ROW_W  = 6;
  localparam int ROWS_USED_W = 7;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;
  localparam int COLCNT_W   = 5;
  localparam int FIXROWS_W  = 7;

  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIXED_ROWS   = 1'd1;

  localparam logic [CMD_W-1:0] CMD_CLEAR = 1'b0;
  localparam logic [CMD_W-1:0] CMD_PLACE = 1'b1;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_SCAN,
    ST_MARK,
    ST_DONE
  } state_t;

endpackage

/* hdl/gsp_if.sv */
// ---------------------------------------------------------------------------
// gsp_in_if / gsp_out_if
// Valid/ready channels for command items and placement results.
// ---------------------------------------------------------------------------
interface gsp_in_if;
  logic                               valid;
  logic                               ready;
  logic [gsp_pkg::CMD_W-1:0]          cmd;
  logic [gsp_pkg::COL_SPAN_W-1:0]     col_span;
  logic [gsp_pkg::ROW_SPAN_W-1:0]     row_span;

  modport source (output valid, cmd, col_span, row_span, input ready);
  modport sink   (input valid, cmd, col_span, row_span, output ready);
endinterface

interface gsp_out_if;
  logic                               valid;
  logic                               ready;
  logic                               placed;
  logic [gsp_pkg::SLOT_COL_W-1:0]     slot_col;
  logic [gsp_pkg::SLOT_ROW_W-1:0]     slot_row;
  logic [gsp_pkg::ROWS_USED_W-1:0]    rows_used;

  modport source (output valid, placed, slot_col, slot_row, rows_used, input ready);
  modport sink   (input valid, placed, slot_col, slot_row, rows_used, output ready);
endinterface

/* hdl/gsp_ram.sv */
// ---------------------------------------------------------------------------
// gsp_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
module gsp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic                                  rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hdl/gsp_fit.sv */
// ---------------------------------------------------------------------------
// gsp_fit
// Finds the leftmost column where a span window is free in an occupancy
// row, within [start_col, cols - col_span].
// ---------------------------------------------------------------------------
module gsp_fit #(
  parameter int MAX_COLS = gsp_pkg::DEF_MAX_COLS
) (
  input  logic [MAX_COLS-1:0]                         occ,
  input  logic [MAX_COLS-1:0]                         span_mask,
  input  logic [$clog2(MAX_COLS+1)-1:0]               start_col,
  input  logic [$clog2(MAX_COLS+1)-1:0]               cols,
  input  logic [$clog2(MAX_COLS+1)-1:0]               col_span,
  output logic                                        fit_found,
  output logic [(MAX_COLS > 1 ? $clog2(MAX_COLS) : 1)-1:0] fit_col
);

  localparam int COL_W = MAX_COLS > 1 ? $clog2(MAX_COLS) : 1;

  logic [MAX_COLS-1:0] ok;

  always_comb begin
    for (int c = 0; c < MAX_COLS; c++) begin
      ok[c] = (((occ >> c) & span_mask) == '0) &&
              (c >= int'(start_col)) &&
              (c + int'(col_span) <= int'(cols));
    end
  end

  // lowest set bit wins
  always_comb begin
    fit_col = '0;
    for (int c = MAX_COLS - 1; c >= 0; c--) begin
      if (ok[c]) begin
        fit_col = COL_W'(c);
      end
    end
  end

  assign fit_found = |ok;

endmodule

/* hdl/grid_span_first_fit_placer.sv */
// ---------------------------------------------------------------------------
// grid_span_first_fit_placer
// First-fit placement of rectangles on an occupancy grid kept in RAM.
//
//   channel  dir  handshake          payload
//   in_ch    in   valid/ready        cmd, col_span, row_span
//   out_ch   out  valid/ready        placed, slot_col, slot_row, rows_used
//   cfg_*    in   cfg_wr_en          cfg_index, cfg_wdata (no read-back)
//
// Clear: accept, sweep every RAM row to zero, then post the result.
// Place: accept, then scan with one RAM row read per cycle (a top row
//   is dropped once the OR of its rows leaves no window), then a
//   read-modify-write of each of the row_span rows, then post the result.
// After reset a sweep clears every RAM row; in_ch is not ready then.
// One item at a time; a new one starts while the last result waits on out_ch.
// ---------------------------------------------------------------------------
module grid_span_first_fit_placer #(
  parameter int MAX_COLS = gsp_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS = gsp_pkg::DEF_MAX_ROWS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  gsp_in_if.sink                          in_ch,
  gsp_out_if.source                       out_ch,
  input  logic                            cfg_wr_en,
  input  logic [gsp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gsp_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int COL_W  = MAX_COLS > 1 ? $clog2(MAX_COLS) : 1;
  localparam int CCNT_W = $clog2(MAX_COLS + 1);
  localparam int ROW_W  = MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1;
  localparam int RCNT_W = $clog2(MAX_ROWS + 1);
  localparam int SUM_W  = RCNT_W + 1;

  // control
  gsp_pkg::state_t                 state_r, state_nxt;
  logic [ROW_W-1:0]                clr_r, clr_nxt;
  logic                            clr_reply_r, clr_reply_nxt;
  logic [CCNT_W-1:0]               cursor_col_r, cursor_col_nxt;
  logic [ROW_W-1:0]                cursor_row_r, cursor_row_nxt;
  logic [RCNT_W-1:0]               used_r, used_nxt;
  logic [gsp_pkg::COLCNT_W-1:0]    column_count_r;
  logic [gsp_pkg::FIXROWS_W-1:0]   fixed_rows_r;
  logic                            out_valid_r, out_valid_nxt;

  // payload
  logic [ROW_W-1:0]                cand_r, cand_nxt;
  logic [ROW_W-1:0]                k_r, k_nxt;
  logic [MAX_COLS-1:0]             acc_r, acc_nxt;
  logic [MAX_COLS-1:0]             span_mask_r, span_mask_nxt;
  logic [CCNT_W-1:0]               start_col_r, start_col_nxt;
  logic [CCNT_W-1:0]               cols_r, cols_nxt;
  logic [CCNT_W-1:0]               cs_r, cs_nxt;
  logic [RCNT_W-1:0]               rs_r, rs_nxt;
  logic [RCNT_W-1:0]               limit_r, limit_nxt;
  logic [COL_W-1:0]                fc_r, fc_nxt;
  logic                            res_placed_r, res_placed_nxt;
  logic [COL_W-1:0]                res_col_r, res_col_nxt;
  logic [ROW_W-1:0]                res_row_r, res_row_nxt;
  logic                            out_placed_r, out_placed_nxt;
  logic [gsp_pkg::SLOT_COL_W-1:0]  out_col_r, out_col_nxt;
  logic [gsp_pkg::SLOT_ROW_W-1:0]  out_row_r, out_row_nxt;
  logic [gsp_pkg::ROWS_USED_W-1:0] out_used_r, out_used_nxt;

  // memory
  logic                            wr_en, rd_en;
  logic [ROW_W-1:0]                wr_addr, rd_addr;
  logic [MAX_COLS-1:0]             wr_data, rd_data;

  logic [MAX_COLS-1:0]             acc_new;
  logic                            fit_found;
  logic [COL_W-1:0]                fit_col;

  gsp_ram #(
    .WIDTH (MAX_COLS),
    .DEPTH (MAX_ROWS)
  ) u_occ_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign acc_new = acc_r | rd_data;

  gsp_fit #(
    .MAX_COLS (MAX_COLS)
  ) u_fit (
    .occ       (acc_new),
    .span_mask (span_mask_r),
    .start_col (start_col_r),
    .cols      (cols_r),
    .col_span  (cs_r),
    .fit_found (fit_found),
    .fit_col   (fit_col)
  );

  assign in_ch.ready      = (state_r == gsp_pkg::ST_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.placed    = out_placed_r;
  assign out_ch.slot_col  = out_col_r;
  assign out_ch.slot_row  = out_row_r;
  assign out_ch.rows_used = out_used_r;

  always_comb begin
    logic [gsp_pkg::COL_SPAN_W-1:0] cs_in;
    logic [gsp_pkg::ROW_SPAN_W-1:0] rs_in;
    int                             cols_i;
    int                             limit_i;
    logic                           last_row;

    state_nxt      = state_r;
    clr_nxt        = clr_r;
    clr_reply_nxt  = clr_reply_r;
    cursor_col_nxt = cursor_col_r;
    cursor_row_nxt = cursor_row_r;
    used_nxt       = used_r;
    out_valid_nxt  = out_valid_r;
    cand_nxt       = cand_r;
    k_nxt          = k_r;
    acc_nxt        = acc_r;
    span_mask_nxt  = span_mask_r;
    start_col_nxt  = start_col_r;
    cols_nxt       = cols_r;
    cs_nxt         = cs_r;
    rs_nxt         = rs_r;
    limit_nxt      = limit_r;
    fc_nxt         = fc_r;
    res_placed_nxt = res_placed_r;
    res_col_nxt    = res_col_r;
    res_row_nxt    = res_row_r;
    out_placed_nxt = out_placed_r;
    out_col_nxt    = out_col_r;
    out_row_nxt    = out_row_r;
    out_used_nxt   = out_used_r;
    wr_en          = 1'b0;
    wr_addr        = '0;
    wr_data        = '0;

    cs_in    = (in_ch.col_span == '0) ? gsp_pkg::COL_SPAN_W'(1) : in_ch.col_span;
    rs_in    = (in_ch.row_span == '0) ? gsp_pkg::ROW_SPAN_W'(1) : in_ch.row_span;
    cols_i   = (int'(column_count_r) > MAX_COLS) ? MAX_COLS : int'(column_count_r);
    limit_i  = (fixed_rows_r == '0 || int'(fixed_rows_r) > MAX_ROWS) ?
               MAX_ROWS : int'(fixed_rows_r);
    last_row = (SUM_W'(k_r) + SUM_W'(1)) == SUM_W'(rs_r);

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      gsp_pkg::ST_CLR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        wr_data = '0;
        clr_nxt = clr_r + ROW_W'(1);
        if (clr_r == ROW_W'(MAX_ROWS - 1)) begin
          clr_nxt = '0;
          if (clr_reply_r) begin
            res_placed_nxt = 1'b0;
            res_col_nxt    = '0;
            res_row_nxt    = '0;
            state_nxt      = gsp_pkg::ST_DONE;
          end else begin
            state_nxt = gsp_pkg::ST_IDLE;
          end
        end
      end

      gsp_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.cmd == gsp_pkg::CMD_CLEAR) begin
            cursor_col_nxt = '0;
            cursor_row_nxt = '0;
            used_nxt       = '0;
            clr_nxt        = '0;
            clr_reply_nxt  = 1'b1;
            state_nxt      = gsp_pkg::ST_CLR;
          end else begin
            for (int c = 0; c < MAX_COLS; c++) begin
              span_mask_nxt[c] = (c < int'(cs_in));
            end
            cols_nxt      = CCNT_W'(cols_i);
            cs_nxt        = CCNT_W'(cs_in);
            rs_nxt        = RCNT_W'(rs_in);
            limit_nxt     = RCNT_W'(limit_i);
            cand_nxt      = cursor_row_r;
            start_col_nxt = cursor_col_r;
            k_nxt         = '0;
            acc_nxt       = '0;
            if (cols_i > 0 && int'(cs_in) <= cols_i &&
                int'(cursor_row_r) + int'(rs_in) <= limit_i) begin
              state_nxt = gsp_pkg::ST_SCAN;
            end else begin
              res_placed_nxt = 1'b0;
              res_col_nxt    = '0;
              res_row_nxt    = '0;
              state_nxt      = gsp_pkg::ST_DONE;
            end
          end
        end
      end

      gsp_pkg::ST_SCAN: begin
        // rd_data holds row cand_r + k_r
        if (!fit_found) begin
          // no window survives this top row: move one row down, or refuse when no lower row fits
          if (SUM_W'(cand_r) + SUM_W'(1) + SUM_W'(rs_r) <= SUM_W'(limit_r)) begin
            cand_nxt      = cand_r + ROW_W'(1);
            k_nxt         = '0;
            acc_nxt       = '0;
            start_col_nxt = '0;
          end else begin
            res_placed_nxt = 1'b0;
            res_col_nxt    = '0;
            res_row_nxt    = '0;
            state_nxt      = gsp_pkg::ST_DONE;
          end
        end else if (last_row) begin
          fc_nxt    = fit_col;
          k_nxt     = '0;
          state_nxt = gsp_pkg::ST_MARK;
        end else begin
          k_nxt   = k_r + ROW_W'(1);
          acc_nxt = acc_new;
        end
      end

      gsp_pkg::ST_MARK: begin
        wr_en   = 1'b1;
        wr_addr = ROW_W'(SUM_W'(cand_r) + SUM_W'(k_r));
        wr_data = rd_data | (span_mask_r << fc_r);
        if (last_row) begin
          cursor_col_nxt = CCNT_W'(int'(fc_r) + int'(cs_r));
          cursor_row_nxt = cand_r;
          if (SUM_W'(cand_r) + SUM_W'(rs_r) > SUM_W'(used_r)) begin
            used_nxt = RCNT_W'(SUM_W'(cand_r) + SUM_W'(rs_r));
          end
          res_placed_nxt = 1'b1;
          res_col_nxt    = fc_r;
          res_row_nxt    = cand_r;
          state_nxt      = gsp_pkg::ST_DONE;
        end else begin
          k_nxt = k_r + ROW_W'(1);
        end
      end

      gsp_pkg::ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_placed_nxt = res_placed_r;
          out_col_nxt    = gsp_pkg::SLOT_COL_W'(res_col_r);
          out_row_nxt    = gsp_pkg::SLOT_ROW_W'(res_row_r);
          out_used_nxt   = gsp_pkg::ROWS_USED_W'(used_r);
          state_nxt      = gsp_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = gsp_pkg::ST_IDLE;
      end
    endcase

    // reads are issued in the cycle before the row they serve, from the next-state address
    rd_en   = (state_nxt == gsp_pkg::ST_SCAN) || (state_nxt == gsp_pkg::ST_MARK);
    rd_addr = ROW_W'(SUM_W'(cand_nxt) + SUM_W'(k_nxt));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= gsp_pkg::ST_CLR;
      clr_r          <= '0;
      clr_reply_r    <= 1'b0;
      cursor_col_r   <= '0;
      cursor_row_r   <= '0;
      used_r         <= '0;
      out_valid_r    <= 1'b0;
      column_count_r <= gsp_pkg::COLCNT_W'(1);
      fixed_rows_r   <= '0;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      clr_reply_r  <= clr_reply_nxt;
      cursor_col_r <= cursor_col_nxt;
      cursor_row_r <= cursor_row_nxt;
      used_r       <= used_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_wr_en) begin
        case (cfg_index)
          gsp_pkg::REG_COLUMN_COUNT: column_count_r <= gsp_pkg::COLCNT_W'(cfg_wdata);
          gsp_pkg::REG_FIXED_ROWS:   fixed_rows_r   <= gsp_pkg::FIXROWS_W'(cfg_wdata);
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cand_r       <= cand_nxt;
    k_r          <= k_nxt;
    acc_r        <= acc_nxt;
    span_mask_r  <= span_mask_nxt;
    start_col_r  <= start_col_nxt;
    cols_r       <= cols_nxt;
    cs_r         <= cs_nxt;
    rs_r         <= rs_nxt;
    limit_r      <= limit_nxt;
    fc_r         <= fc_nxt;
    res_placed_r <= res_placed_nxt;
    res_col_r    <= res_col_nxt;
    res_row_r    <= res_row_nxt;
    out_placed_r <= out_placed_nxt;
    out_col_r    <= out_col_nxt;
    out_row_r    <= out_row_nxt;
    out_used_r   <= out_used_nxt;
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Checks the grid span first-fit placer against a cycle-free placement
// predictor. It runs directed corner items, then random phases with
// different column and row settings, and finally a long output stall that
// backs up the input. Sender gaps and receiver stalls vary from phase to
// phase.
// ---------------------------------------------------------------------------
module testbench;

  localparam int GRID_COLS = gsp_pkg::DEF_MAX_COLS;
  localparam int GRID_ROWS = gsp_pkg::DEF_MAX_ROWS;

  typedef struct packed {
    logic                            placed;
    logic [gsp_pkg::SLOT_COL_W-1:0]  slot_col;
    logic [gsp_pkg::SLOT_ROW_W-1:0]  slot_row;
    logic [gsp_pkg::ROWS_USED_W-1:0] rows_used;
  } placement_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                           cfg_wr_en;
  logic [gsp_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [gsp_pkg::CFG_DATA_W-1:0] cfg_wdata;

  gsp_in_if  in_ch ();
  gsp_out_if out_ch ();

  grid_span_first_fit_placer #(
    .MAX_COLS (GRID_COLS),
    .MAX_ROWS (GRID_ROWS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [GRID_COLS-1:0]          occ_rows [GRID_ROWS];
  int                            cursor_c;
  int                            cursor_r;
  int                            rows_reached;
  logic [gsp_pkg::COLCNT_W-1:0]  col_setting;
  logic [gsp_pkg::FIXROWS_W-1:0] row_setting;

  placement_t pending_placements[$];

  int mismatches = 0;
  int items_sent = 0;
  int clears_sent = 0;
  int placed_seen = 0;
  int refused_seen = 0;

  // idling controls
  int gap_style = 0;
  int stall_style = 0;
  int burst_left = 0;
  int hold_request = 0;

  function automatic placement_t predict_placement(
      input logic [gsp_pkg::CMD_W-1:0]      cmd,
      input logic [gsp_pkg::COL_SPAN_W-1:0] cs_in,
      input logic [gsp_pkg::ROW_SPAN_W-1:0] rs_in);
    placement_t res;
    int cs, rs, cols, lim, r, c, k, fc, fr;
    bit found, clash;
    logic [GRID_COLS-1:0] span_mask;
    res = '0;
    if (cmd == gsp_pkg::CMD_CLEAR) begin
      foreach (occ_rows[i]) occ_rows[i] = '0;
      cursor_c = 0;
      cursor_r = 0;
      rows_reached = 0;
      return res;
    end
    cs = (cs_in == 0) ? 1 : int'(cs_in);
    rs = (rs_in == 0) ? 1 : int'(rs_in);
    cols = (col_setting > GRID_COLS) ? GRID_COLS : int'(col_setting);
    lim = (row_setting == 0) ? GRID_ROWS
        : ((row_setting > GRID_ROWS) ? GRID_ROWS : int'(row_setting));
    found = 0;
    fc = 0;
    fr = 0;
    if (cols > 0 && cs <= cols && rs <= lim) begin
      r = cursor_r;
      c = cursor_c;
      while (!found && r + rs <= lim) begin
        while (!found && c + cs <= cols) begin
          span_mask = GRID_COLS'(((32'd1 << cs) - 32'd1) << c);
          clash = 0;
          for (k = 0; k < rs; k++) begin
            if ((occ_rows[r + k] & span_mask) != '0) clash = 1;
          end
          if (!clash) begin
            found = 1;
            fc = c;
            fr = r;
          end else begin
            c++;
          end
        end
        c = 0;
        r++;
      end
    end
    if (found) begin
      span_mask = GRID_COLS'(((32'd1 << cs) - 32'd1) << fc);
      for (k = 0; k < rs; k++) occ_rows[fr + k] |= span_mask;
      cursor_c = fc + cs;
      cursor_r = fr;
      if (fr + rs > rows_reached) rows_reached = fr + rs;
    end
    res.placed = found;
    res.slot_col = fc[gsp_pkg::SLOT_COL_W-1:0];
    res.slot_row = fr[gsp_pkg::SLOT_ROW_W-1:0];
    res.rows_used = rows_reached[gsp_pkg::ROWS_USED_W-1:0];
    return res;
  endfunction

  task automatic send_item(input logic [gsp_pkg::CMD_W-1:0]      cmd,
                           input logic [gsp_pkg::COL_SPAN_W-1:0] cs,
                           input logic [gsp_pkg::ROW_SPAN_W-1:0] rs);
    int gap;
    placement_t predicted;
    in_ch.valid <= 1'b1;
    in_ch.cmd <= cmd;
    in_ch.col_span <= cs;
    in_ch.row_span <= rs;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predicted = predict_placement(cmd, cs, rs);
    pending_placements = {pending_placements, predicted};
    items_sent++;
    if (cmd == gsp_pkg::CMD_CLEAR) clears_sent++;
    if (gap_style != 0) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = (gap_style == 1) ? $urandom_range(0, 7) : $urandom_range(0, 2);
        gap = (gap_style == 1) ? $urandom_range(1, 6) : $urandom_range(1, 20);
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic wait_until_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_placements.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [gsp_pkg::CFG_IDX_W-1:0]  idx,
                                input logic [gsp_pkg::CFG_DATA_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == gsp_pkg::REG_COLUMN_COUNT) col_setting = value[gsp_pkg::COLCNT_W-1:0];
    else row_setting = value[gsp_pkg::FIXROWS_W-1:0];
    @(posedge clk);
  endtask

  task automatic set_grid(input int cols, input int fixed);
    wait_until_idle();
    write_register(gsp_pkg::REG_COLUMN_COUNT, gsp_pkg::CFG_DATA_W'(cols));
    write_register(gsp_pkg::REG_FIXED_ROWS, gsp_pkg::CFG_DATA_W'(fixed));
  endtask

  task automatic test_directed_cases();
    // reset settings: one column, growing rows
    send_item(gsp_pkg::CMD_PLACE, 5'd1, 7'd1);
    send_item(gsp_pkg::CMD_PLACE, 5'd0, 7'd0);     // zero spans act as 1x1
    set_grid(16, 0);
    send_item(gsp_pkg::CMD_PLACE, 5'd16, 7'd1);
    send_item(gsp_pkg::CMD_PLACE, 5'd17, 7'd1);    // wider than the grid
    send_item(gsp_pkg::CMD_PLACE, 5'd31, 7'd127);
    send_item(gsp_pkg::CMD_PLACE, 5'd1, 7'd64);    // cursor below row 0, no room
    send_item(gsp_pkg::CMD_CLEAR, 5'd31, 7'd127);
    send_item(gsp_pkg::CMD_PLACE, 5'd16, 7'd64);   // whole grid
    send_item(gsp_pkg::CMD_PLACE, 5'd1, 7'd1);
    send_item(gsp_pkg::CMD_CLEAR, 5'd0, 7'd0);
    set_grid(0, 0);
    send_item(gsp_pkg::CMD_PLACE, 5'd1, 7'd1);
    set_grid(31, 127);                             // both clamp to the maximum
    send_item(gsp_pkg::CMD_PLACE, 5'd16, 7'd2);
    send_item(gsp_pkg::CMD_PLACE, 5'd16, 7'd127);
    set_grid(31, 1);                               // cursor column now past the last column
    send_item(gsp_pkg::CMD_PLACE, 5'd1, 7'd1);
    send_item(gsp_pkg::CMD_CLEAR, 5'd1, 7'd1);
    send_item(gsp_pkg::CMD_PLACE, 5'd1, 7'd2);
    send_item(gsp_pkg::CMD_PLACE, 5'd16, 7'd1);
    send_item(gsp_pkg::CMD_PLACE, 5'd1, 7'd1);
    set_grid(5, 64);
    send_item(gsp_pkg::CMD_PLACE, 5'd3, 7'd1);
    send_item(gsp_pkg::CMD_PLACE, 5'd3, 7'd1);
    send_item(gsp_pkg::CMD_PLACE, 5'd5, 7'd63);
    send_item(gsp_pkg::CMD_CLEAR, 5'd0, 7'd0);
    send_item(gsp_pkg::CMD_PLACE, 5'd5, 7'd63);
    send_item(gsp_pkg::CMD_PLACE, 5'd0, 7'd0);     // lands on the last row
    send_item(gsp_pkg::CMD_CLEAR, 5'd0, 7'd0);
  endtask

  task automatic test_random_phases();
    int phase, n, roll, cols, fixed, col_cap, row_cap;
    logic [gsp_pkg::COL_SPAN_W-1:0] cs;
    logic [gsp_pkg::ROW_SPAN_W-1:0] rs;
    for (phase = 0; phase < 10; phase++) begin
      case (phase)
        0: begin cols = 16; fixed = 0; end
        1: begin cols = 1; fixed = 0; end
        2: begin cols = 31; fixed = 127; end
        3: begin cols = 0; fixed = 9; end
        4: begin cols = 16; fixed = 64; end
        5: begin cols = 16; fixed = 1; end
        default: begin
          cols = $urandom_range(1, 16);
          fixed = $urandom_range(0, 64);
        end
      endcase
      set_grid(cols, fixed);
      gap_style = phase % 3;
      stall_style = (phase / 3) % 3;
      col_cap = (cols > GRID_COLS) ? GRID_COLS : ((cols == 0) ? GRID_COLS : cols);
      row_cap = (fixed == 0 || fixed > GRID_ROWS) ? GRID_ROWS : fixed;
      for (n = 0; n < 86; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 4) begin
          send_item(gsp_pkg::CMD_CLEAR, gsp_pkg::COL_SPAN_W'($urandom),
                    gsp_pkg::ROW_SPAN_W'($urandom));
        end else if (roll < 12) begin
          // raw fields, any bit pattern
          send_item(gsp_pkg::CMD_PLACE, gsp_pkg::COL_SPAN_W'($urandom),
                    gsp_pkg::ROW_SPAN_W'($urandom));
        end else begin
          cs = gsp_pkg::COL_SPAN_W'($urandom_range(1, col_cap));
          roll = $urandom_range(0, 99);
          if (roll < 70) begin
            rs = gsp_pkg::ROW_SPAN_W'($urandom_range(1, (row_cap < 4) ? row_cap : 4));
          end else if (roll < 95) begin
            rs = gsp_pkg::ROW_SPAN_W'($urandom_range(1, (row_cap < 16) ? row_cap : 16));
          end else begin
            rs = gsp_pkg::ROW_SPAN_W'($urandom_range(1, row_cap));
          end
          send_item(gsp_pkg::CMD_PLACE, cs, rs);
        end
      end
    end
  endtask

  task automatic test_output_backpressure();
    int n;
    set_grid(16, 0);
    gap_style = 0;
    stall_style = 0;
    hold_request = 300;
    for (n = 0; n < 12; n++) begin
      send_item(gsp_pkg::CMD_PLACE, gsp_pkg::COL_SPAN_W'($urandom_range(1, 6)),
                gsp_pkg::ROW_SPAN_W'($urandom_range(1, 3)));
    end
    wait_until_idle();
  endtask

  // result receiver: own stall pattern plus a counted long hold-off
  initial begin : result_receiver
    int hold_left;
    int tick;
    hold_left = 0;
    tick = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (stall_style)
          1: out_ch.ready <= ($urandom_range(0, 99) < 70);
          2: out_ch.ready <= ((tick % 11) < 6);
          default: out_ch.ready <= 1'b1;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    placement_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (out_ch.placed) placed_seen++;
      else refused_seen++;
      if (pending_placements.size() == 0) begin
        mismatches++;
        $display("%0t: result with nothing expected: placed=%0d col=%0d row=%0d used=%0d",
                 $time, out_ch.placed, out_ch.slot_col, out_ch.slot_row, out_ch.rows_used);
      end else begin
        want = pending_placements.pop_front();
        if (out_ch.placed !== want.placed || out_ch.slot_col !== want.slot_col ||
            out_ch.slot_row !== want.slot_row || out_ch.rows_used !== want.rows_used) begin
          mismatches++;
          $display("%0t: mismatch expected placed=%0d col=%0d row=%0d used=%0d",
                   $time, want.placed, want.slot_col, want.slot_row, want.rows_used);
          $display("%0t:          actual   placed=%0d col=%0d row=%0d used=%0d",
                   $time, out_ch.placed, out_ch.slot_col, out_ch.slot_row, out_ch.rows_used);
        end
      end
    end
  end

  initial begin : watchdog
    #200_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin : run_tests
    in_ch.valid = 1'b0;
    in_ch.cmd = gsp_pkg::CMD_CLEAR;
    in_ch.col_span = '0;
    in_ch.row_span = '0;
    cfg_wr_en = 1'b0;
    cfg_index = gsp_pkg::REG_COLUMN_COUNT;
    cfg_wdata = '0;
    rst_n = 1'b0;
    foreach (occ_rows[i]) occ_rows[i] = '0;
    cursor_c = 0;
    cursor_r = 0;
    rows_reached = 0;
    col_setting = gsp_pkg::COLCNT_W'(1);
    row_setting = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_random_phases();
    test_output_backpressure();

    wait_until_idle();
    repeat (GRID_ROWS + 16) @(posedge clk);
    $display("covered %0d items (%0d clears): corner cases, random grid settings",
             items_sent, clears_sent);
    $display("and a long output hold-off; %0d placed, %0d not placed, %0d mismatches",
             placed_seen, refused_seen, mismatches);
    if (mismatches == 0 && pending_placements.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
